// ===== src/pllm_pkg.sv =====
// Shared types and constants for the pooled linked list manager.
package pllm_pkg;

  // Number of nodes in the pool
  localparam int POOL_SIZE = 16;

  // Width of every pool index field on the channels
  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

endpackage

// ===== src/pllm_cmd_if.sv =====
// Command channel: one list operation per beat.
interface pllm_cmd_if import pllm_pkg::*; #(
  parameter int KEY_BITS   = 20,
  parameter int GRADE_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic                  at_head;
  logic [IDX_W-1:0]      pred_index;
  logic [KEY_BITS-1:0]   new_key;
  logic [GRADE_BITS-1:0] new_grade;
  logic [IDX_W-1:0]      read_index;

  modport source (
    output valid, opcode, at_head, pred_index, new_key, new_grade, read_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, at_head, pred_index, new_key, new_grade, read_index,
    output ready
  );
endinterface

// ===== src/pllm_rsp_if.sv =====
// Response channel: one result per command beat.
interface pllm_rsp_if import pllm_pkg::*; #(
  parameter int KEY_BITS   = 20,
  parameter int GRADE_BITS = 10
);
  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic [IDX_W-1:0]           node_index;
  logic signed [KEY_BITS:0]   node_key;
  logic signed [GRADE_BITS:0] node_grade;
  logic [IDX_W-1:0]           node_next;
  logic                       next_is_nil;
  logic [IDX_W-1:0]           list_head;
  logic                       list_empty;
  logic [IDX_W-1:0]           free_head;
  logic                       pool_full;

  modport source (
    output valid, status, node_index, node_key, node_grade, node_next,
           next_is_nil, list_head, list_empty, free_head, pool_full,
    input  ready
  );
  modport sink (
    input  valid, status, node_index, node_key, node_grade, node_next,
           next_is_nil, list_head, list_empty, free_head, pool_full,
    output ready
  );
endinterface

// ===== src/pllm_node_ram.sv =====
// Node pool storage: link memory and key/grade memory, registered reads.
module pllm_node_ram #(
  parameter int DEPTH   = 16,
  parameter int AW      = 4,
  parameter int LINK_W  = 5,
  parameter int KEY_W   = 21,
  parameter int GRADE_W = 11
) (
  input  logic               clk,
  input  logic               link_we,
  input  logic [AW-1:0]      link_waddr,
  input  logic [LINK_W-1:0]  link_wdata,
  input  logic               data_we,
  input  logic [AW-1:0]      data_waddr,
  input  logic [KEY_W-1:0]   key_wdata,
  input  logic [GRADE_W-1:0] grade_wdata,
  input  logic [AW-1:0]      raddr,
  output logic [LINK_W-1:0]  link_rdata,
  output logic [KEY_W-1:0]   key_rdata,
  output logic [GRADE_W-1:0] grade_rdata
);

  logic [LINK_W-1:0]  link_mem  [DEPTH];
  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [GRADE_W-1:0] grade_mem [DEPTH];

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[raddr];
  end

  // key and grade memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      key_mem[data_waddr]   <= key_wdata;
      grade_mem[data_waddr] <= grade_wdata;
    end
    key_rdata   <= key_mem[raddr];
    grade_rdata <= grade_mem[raddr];
  end

endmodule

// ===== src/pooled_linked_list_manager.sv =====
// Pooled linked list manager: sequencer over a link memory and a data memory.
// A command runs its states, then S_DONE: none if rejected; S_INS_A for a head insert,
// S_DEL_HEAD for a head delete, S_RD for a read; S_INS_A to S_INS_C or S_DEL_P to S_DEL_R
// after a predecessor, S_DEL_P alone if that has no successor. One command at a time: the
// next beat is taken in S_IDLE after the response loads; a stalled response delays the
// load. Reset (rst, synchronous) runs an init pass over every node that chains the free
// list and clears all keys and grades to all ones; no command is taken then.
module pooled_linked_list_manager import pllm_pkg::*; #(
  parameter int KEY_BITS   = 20,
  parameter int GRADE_BITS = 10
) (
  input logic clk,
  input logic rst,
  pllm_cmd_if.sink   cmd,
  pllm_rsp_if.source rsp
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int PW = $clog2(POOL_SIZE + 1);
  localparam int KW = KEY_BITS + 1;
  localparam int GW = GRADE_BITS + 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);
  localparam logic [PW-1:0] LAST = PW'(POOL_SIZE - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_INS_A, S_INS_B, S_INS_C,
    S_DEL_HEAD, S_DEL_P, S_DEL_Q, S_DEL_R, S_RD, S_DONE
  } state_t;

  state_t          state;
  logic [PW-1:0]   cnt;
  logic [PW-1:0]   head;
  logic [PW-1:0]   free;
  logic [PW-1:0]   t;
  logic [PW-1:0]   pred;
  logic            at_head;
  logic [KW-1:0]   r_key;
  logic [GW-1:0]   r_grade;
  logic [PW-1:0]   r_next;
  status_t         r_status;
  logic            r_has;

  logic            accept;
  logic            pred_ok;
  logic            rd_ok;
  logic [PW-1:0]   raddr;
  logic            link_we;
  logic [PW-1:0]   link_waddr;
  logic [PW-1:0]   link_wdata;
  logic            data_we;
  logic [PW-1:0]   data_waddr;
  logic [KW-1:0]   key_wdata;
  logic [GW-1:0]   grade_wdata;
  logic [PW-1:0]   link_rdata;
  logic [KW-1:0]   key_rdata;
  logic [GW-1:0]   grade_rdata;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign pred_ok   = int'(cmd.pred_index) < POOL_SIZE;
  assign rd_ok     = int'(cmd.read_index) < POOL_SIZE;

  pllm_node_ram #(
    .DEPTH   (POOL_SIZE),
    .AW      (AW),
    .LINK_W  (PW),
    .KEY_W   (KW),
    .GRADE_W (GW)
  ) u_ram (
    .clk         (clk),
    .link_we     (link_we),
    .link_waddr  (link_waddr[AW-1:0]),
    .link_wdata  (link_wdata),
    .data_we     (data_we),
    .data_waddr  (data_waddr[AW-1:0]),
    .key_wdata   (key_wdata),
    .grade_wdata (grade_wdata),
    .raddr       (raddr[AW-1:0]),
    .link_rdata  (link_rdata),
    .key_rdata   (key_rdata),
    .grade_rdata (grade_rdata)
  );

  // read address: issued in the state before the one that uses the data
  always_comb begin
    raddr = '0;
    case (state)
      S_IDLE: begin
        case (cmd.opcode)
          OP_INSERT: raddr = free;
          OP_DELETE: raddr = cmd.at_head ? head : PW'(cmd.pred_index);
          OP_READ:   raddr = PW'(cmd.read_index);
          default:   raddr = '0;
        endcase
      end
      S_INS_A: raddr = pred;
      S_DEL_P: raddr = link_rdata;
      default: raddr = '0;
    endcase
  end

  // memory writes
  always_comb begin
    link_we     = 1'b0;
    link_waddr  = t;
    link_wdata  = free;
    data_we     = 1'b0;
    data_waddr  = t;
    key_wdata   = '1;
    grade_wdata = '1;
    case (state)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = cnt;
        link_wdata = cnt + PW'(1);
        data_we    = 1'b1;
        data_waddr = cnt;
      end
      S_INS_A: begin
        data_we     = 1'b1;
        key_wdata   = r_key;
        grade_wdata = r_grade;
        link_we     = at_head;
        link_wdata  = head;
      end
      S_INS_B: begin
        link_we    = 1'b1;
        link_wdata = link_rdata;
      end
      S_INS_C: begin
        link_we    = 1'b1;
        link_waddr = pred;
        link_wdata = t;
      end
      S_DEL_HEAD, S_DEL_R: begin
        link_we = 1'b1;
        data_we = 1'b1;
      end
      S_DEL_Q: begin
        link_we    = 1'b1;
        link_waddr = pred;
        link_wdata = link_rdata;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  // sequencer, pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      head      <= NIL;
      free      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // response slot: a load takes priority over a drained beat
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + PW'(1);
          if (cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pred    <= PW'(cmd.pred_index);
            at_head <= cmd.at_head;
            r_key   <= {1'b0, cmd.new_key};
            r_grade <= {1'b0, cmd.new_grade};
            r_has   <= 1'b0;
            case (cmd.opcode)
              OP_INSERT: begin
                if (free == NIL) begin
                  r_status <= ST_FULL;
                  state    <= S_DONE;
                end else if (cmd.at_head || pred_ok) begin
                  t     <= free;
                  state <= S_INS_A;
                end else begin
                  r_status <= ST_INVALID;
                  state    <= S_DONE;
                end
              end
              OP_DELETE: begin
                if (head == NIL) begin
                  r_status <= ST_EMPTY;
                  state    <= S_DONE;
                end else if (cmd.at_head) begin
                  t     <= head;
                  state <= S_DEL_HEAD;
                end else if (pred_ok) begin
                  // stays invalid if the predecessor has no successor
                  r_status <= ST_INVALID;
                  state    <= S_DEL_P;
                end else begin
                  r_status <= ST_INVALID;
                  state    <= S_DONE;
                end
              end
              OP_READ: begin
                if (rd_ok) begin
                  t     <= PW'(cmd.read_index);
                  state <= S_RD;
                end else begin
                  r_status <= ST_INVALID;
                  state    <= S_DONE;
                end
              end
              default: begin
                r_status <= ST_INVALID;
                state    <= S_DONE;
              end
            endcase
          end
        end
        // free head's old link becomes the new free head
        S_INS_A: begin
          free <= link_rdata;
          if (at_head) begin
            head     <= t;
            r_next   <= head;
            r_status <= ST_OK;
            r_has    <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= S_INS_B;
          end
        end
        // new node takes the predecessor's link
        S_INS_B: begin
          r_next <= (pred == t) ? t : link_rdata;
          state  <= S_INS_C;
        end
        S_INS_C: begin
          r_status <= ST_OK;
          r_has    <= 1'b1;
          state    <= S_DONE;
        end
        S_DEL_HEAD: begin
          head     <= link_rdata;
          free     <= t;
          r_next   <= free;
          r_key    <= '1;
          r_grade  <= '1;
          r_status <= ST_OK;
          r_has    <= 1'b1;
          state    <= S_DONE;
        end
        // predecessor link names the victim
        S_DEL_P: begin
          if (link_rdata == NIL) begin
            state <= S_DONE;
          end else begin
            t     <= link_rdata;
            state <= S_DEL_Q;
          end
        end
        S_DEL_Q: begin
          state <= S_DEL_R;
        end
        S_DEL_R: begin
          free     <= t;
          r_next   <= free;
          r_key    <= '1;
          r_grade  <= '1;
          r_status <= ST_OK;
          r_has    <= 1'b1;
          state    <= S_DONE;
        end
        S_RD: begin
          r_next   <= link_rdata;
          r_key    <= key_rdata;
          r_grade  <= grade_rdata;
          r_status <= ST_OK;
          r_has    <= 1'b1;
          state    <= S_DONE;
        end
        // load the response once the slot is free
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.status      <= r_status;
            rsp.node_index  <= r_has ? IDX_W'(t) : '0;
            rsp.node_key    <= r_has ? signed'(r_key) : '0;
            rsp.node_grade  <= r_has ? signed'(r_grade) : '0;
            rsp.node_next   <= (r_has && r_next != NIL) ? IDX_W'(r_next) : '0;
            rsp.next_is_nil <= r_has && (r_next == NIL);
            rsp.list_head   <= (head == NIL) ? '0 : IDX_W'(head);
            rsp.list_empty  <= (head == NIL);
            rsp.free_head   <= (free == NIL) ? '0 : IDX_W'(free);
            rsp.pool_full   <= (free == NIL);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a command beat always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("command beat did not leave idle");

  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !cmd.ready)
    else $error("command taken during init pass");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    head <= NIL && free <= NIL)
    else $error("list or free pointer out of range");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    (!link_we || int'(link_waddr) < POOL_SIZE) && (!data_we || int'(data_waddr) < POOL_SIZE))
    else $error("memory write beyond pool");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |->
      rsp.node_index == '0 && rsp.node_key == '0 && !rsp.next_is_nil)
    else $error("failed response carries node data");

endmodule
